### rtl/core/tpws_pkg.sv
// ----------------------------------------------------------------------------
// tpws_pkg
// Shared types and constants of the time-partition window scheduler.
// ----------------------------------------------------------------------------
package tpws_pkg;

  localparam int MAX_PARTS  = 8;
  localparam int NUM_WIN    = 8;
  localparam int TIME_W     = 32;
  localparam int FRAME_W    = 36;
  localparam int PART_IDX_W = $clog2(MAX_PARTS);
  localparam int WIN_IDX_W  = $clog2(NUM_WIN);

  // action codes
  localparam logic [2:0] ACT_TICK   = 3'd0;
  localparam logic [2:0] ACT_CREATE = 3'd1;
  localparam logic [2:0] ACT_STAGE  = 3'd2;
  localparam logic [2:0] ACT_COMMIT = 3'd3;
  localparam logic [2:0] ACT_QUERY  = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    alu_op_t              op;
    logic [FRAME_W-1:0]   a;
    logic [FRAME_W-1:0]   b;
  } alu_req_t;

  typedef struct packed {
    logic [FRAME_W-1:0]   res;
    logic                 carry;  // on subtract: a >= b
  } alu_rsp_t;

endpackage

### rtl/core/tpws_alu.sv
// ----------------------------------------------------------------------------
// tpws_alu
// Shared add / subtract-compare unit used by the scheduler sequencer.
// ----------------------------------------------------------------------------
module tpws_alu
  import tpws_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [FRAME_W-1:0] b_op;
  logic [FRAME_W:0]   sum;

  assign b_op = (req.op == ALU_SUB) ? ~req.b : req.b;
  assign sum  = {1'b0, req.a} + {1'b0, b_op} +
                {{FRAME_W{1'b0}}, (req.op == ALU_SUB)};

  assign rsp.res   = sum[FRAME_W-1:0];
  assign rsp.carry = sum[FRAME_W];

endmodule

### rtl/core/time_partition_window_scheduler_top.sv
// ----------------------------------------------------------------------------
// time_partition_window_scheduler_top
// Major-frame partition window sequencer with partition budgets.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_* carries one command item (tick, create, stage, commit,
//   query). Result channel out_* returns exactly one item per command.
//   An item is accepted when in_valid is high and in_stall is low; the block
//   holds in_stall high while it works on an item.
//   Stage, query, create, undefined actions and a tick before any commit
//   finish in the decode step. A tick increments the frame time and compares
//   it with the current window end; inside a window it then charges the
//   active partition, if any; at a window end it credits the window, reloads
//   every used partition when the frame wraps (one partition reloaded per
//   cycle) and selects the next window. Commit validates the entries, then
//   sums the end offsets (one entry validated, then one end offset summed,
//   per cycle). All adds and compares go through one shared 36-bit adder.
//   in_stall drops as the result is loaded. A finished result sits in an
//   output register, so a new item is taken while out_stall holds the
//   previous one; the next result waits until the register is free.
//   Reset (rst_n low, synchronous) clears all partitions, the window table
//   and the schedule.
// ----------------------------------------------------------------------------
module time_partition_window_scheduler_top
  import tpws_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            in_action,
  input  logic [2:0]            in_slot,
  input  logic [3:0]            in_part_sel,
  input  logic [31:0]           in_period,
  input  logic [31:0]           in_ticks,
  input  logic [3:0]            in_count,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_status,
  output logic [2:0]            out_part_id,
  output logic                  out_active_valid,
  output logic [2:0]            out_window_index,
  output logic                  out_switched,
  output logic                  out_present,
  output logic [31:0]           out_used_ticks,
  output logic [31:0]           out_left_ticks
);

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_DECODE   = 12'b0000_0000_0010,
    S_TICK_INC = 12'b0000_0000_0100,
    S_TICK_CMP = 12'b0000_0000_1000,
    S_RUN_LEFT = 12'b0000_0001_0000,
    S_RUN_USED = 12'b0000_0010_0000,
    S_CREDIT   = 12'b0000_0100_0000,
    S_RELOAD   = 12'b0000_1000_0000,
    S_SELECT   = 12'b0001_0000_0000,
    S_CHECK    = 12'b0010_0000_0000,
    S_ACCUM    = 12'b0100_0000_0000,
    S_DONE     = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // architectural state
  logic [MAX_PARTS-1:0]    part_used_r,      part_used_nxt;
  logic [TIME_W-1:0]       part_budget_r     [MAX_PARTS];
  logic [TIME_W-1:0]       part_budget_nxt   [MAX_PARTS];
  logic [TIME_W-1:0]       part_time_used_r  [MAX_PARTS];
  logic [TIME_W-1:0]       part_time_used_nxt[MAX_PARTS];
  logic [TIME_W-1:0]       part_time_left_r  [MAX_PARTS];
  logic [TIME_W-1:0]       part_time_left_nxt[MAX_PARTS];
  logic [3:0]              win_part_r        [NUM_WIN];
  logic [3:0]              win_part_nxt      [NUM_WIN];
  logic [TIME_W-1:0]       win_len_r         [NUM_WIN];
  logic [TIME_W-1:0]       win_len_nxt       [NUM_WIN];
  logic [FRAME_W-1:0]      win_end_r         [NUM_WIN];
  logic [FRAME_W-1:0]      win_end_nxt       [NUM_WIN];
  logic [3:0]              win_total_r,      win_total_nxt;
  logic [FRAME_W-1:0]      frame_time_r,     frame_time_nxt;
  logic [WIN_IDX_W-1:0]    cur_window_r,     cur_window_nxt;
  logic                    active_on_r,      active_on_nxt;
  logic [PART_IDX_W-1:0]   active_part_r,    active_part_nxt;
  logic                    sched_on_r,       sched_on_nxt;
  logic                    out_valid_r,      out_valid_nxt;

  // item and work registers
  logic [2:0]              action_r,   action_nxt;
  logic [2:0]              slot_r,     slot_nxt;
  logic [3:0]              sel_r,      sel_nxt;
  logic [31:0]             period_r,   period_nxt;
  logic [31:0]             ticks_r,    ticks_nxt;
  logic [3:0]              count_r,    count_nxt;
  logic [2:0]              idx_r,      idx_nxt;
  logic [WIN_IDX_W-1:0]    nxt_win_r,  nxt_win_r_nxt;
  logic [FRAME_W-1:0]      off_r,      off_nxt;
  logic [1:0]              status_r,   status_nxt;
  logic                    created_r,  created_nxt;
  logic [PART_IDX_W-1:0]   new_id_r,   new_id_nxt;
  logic                    sw_r,       sw_nxt;
  logic                    present_r,  present_nxt;
  logic [TIME_W-1:0]       used_r,     used_nxt;
  logic [TIME_W-1:0]       left_r,     left_nxt;

  // output register
  logic [1:0]              o_status_r,  o_status_nxt;
  logic [2:0]              o_pid_r,     o_pid_nxt;
  logic                    o_act_r,     o_act_nxt;
  logic [2:0]              o_win_r,     o_win_nxt;
  logic                    o_sw_r,      o_sw_nxt;
  logic                    o_pres_r,    o_pres_nxt;
  logic [31:0]             o_used_r,    o_used_nxt;
  logic [31:0]             o_left_r,    o_left_nxt;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  tpws_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  logic                  free_found;
  logic [PART_IDX_W-1:0] free_id;
  logic [3:0]            win_next;
  logic                  last_entry;
  logic [3:0]            sel_part;

  // first free partition slot
  always_comb begin
    free_found = 1'b0;
    free_id    = '0;
    for (int i = MAX_PARTS - 1; i >= 0; i--) begin
      if (!part_used_r[i]) begin
        free_found = 1'b1;
        free_id    = PART_IDX_W'(i);
      end
    end
  end

  assign win_next   = {1'b0, cur_window_r} + 4'd1;
  assign last_entry = ({1'b0, idx_r} == (count_r - 4'd1));
  assign sel_part   = win_part_r[nxt_win_r];

  always_comb begin
    state_nxt          = state_r;
    part_used_nxt      = part_used_r;
    part_budget_nxt    = part_budget_r;
    part_time_used_nxt = part_time_used_r;
    part_time_left_nxt = part_time_left_r;
    win_part_nxt       = win_part_r;
    win_len_nxt        = win_len_r;
    win_end_nxt        = win_end_r;
    win_total_nxt      = win_total_r;
    frame_time_nxt     = frame_time_r;
    cur_window_nxt     = cur_window_r;
    active_on_nxt      = active_on_r;
    active_part_nxt    = active_part_r;
    sched_on_nxt       = sched_on_r;
    out_valid_nxt      = out_valid_r && out_stall;

    action_nxt    = action_r;
    slot_nxt      = slot_r;
    sel_nxt       = sel_r;
    period_nxt    = period_r;
    ticks_nxt     = ticks_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    nxt_win_r_nxt = nxt_win_r;
    off_nxt       = off_r;
    status_nxt    = status_r;
    created_nxt   = created_r;
    new_id_nxt    = new_id_r;
    sw_nxt        = sw_r;
    present_nxt   = present_r;
    used_nxt      = used_r;
    left_nxt      = left_r;

    o_status_nxt = o_status_r;
    o_pid_nxt    = o_pid_r;
    o_act_nxt    = o_act_r;
    o_win_nxt    = o_win_r;
    o_sw_nxt     = o_sw_r;
    o_pres_nxt   = o_pres_r;
    o_used_nxt   = o_used_r;
    o_left_nxt   = o_left_r;

    alu_req.op = ALU_ADD;
    alu_req.a  = '0;
    alu_req.b  = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          action_nxt  = in_action;
          slot_nxt    = in_slot;
          sel_nxt     = in_part_sel;
          period_nxt  = in_period;
          ticks_nxt   = in_ticks;
          count_nxt   = in_count;
          status_nxt  = ST_OK;
          created_nxt = 1'b0;
          sw_nxt      = 1'b0;
          present_nxt = 1'b0;
          used_nxt    = '0;
          left_nxt    = '0;
          state_nxt   = S_DECODE;
        end
      end

      S_DECODE: begin
        state_nxt = S_DONE;
        case (action_r)
          ACT_TICK: begin
            if (sched_on_r && (win_total_r != 4'd0)) begin
              state_nxt = S_TICK_INC;
            end
          end
          ACT_CREATE: begin
            // period - ticks, no carry means ticks above period
            alu_req.op = ALU_SUB;
            alu_req.a  = FRAME_W'(period_r);
            alu_req.b  = FRAME_W'(ticks_r);
            if ((period_r == '0) || (ticks_r == '0) || !alu_rsp.carry) begin
              status_nxt = ST_INVALID;
            end else if (!free_found) begin
              status_nxt = ST_FULL;
            end else begin
              part_used_nxt[free_id]      = 1'b1;
              part_budget_nxt[free_id]    = ticks_r;
              part_time_used_nxt[free_id] = '0;
              part_time_left_nxt[free_id] = ticks_r;
              created_nxt                 = 1'b1;
              new_id_nxt                  = free_id;
            end
          end
          ACT_STAGE: begin
            win_part_nxt[slot_r] = sel_r;
            win_len_nxt[slot_r]  = ticks_r;
          end
          ACT_COMMIT: begin
            if ((count_r == 4'd0) || (count_r > 4'(NUM_WIN)) ||
                (count_r > 4'(MAX_PARTS))) begin
              status_nxt = ST_INVALID;
            end else begin
              idx_nxt   = '0;
              state_nxt = S_CHECK;
            end
          end
          ACT_QUERY: begin
            if (sel_r[3] || !part_used_r[sel_r[2:0]]) begin
              status_nxt = ST_INVALID;
            end else begin
              present_nxt = 1'b1;
              used_nxt    = part_time_used_r[sel_r[2:0]];
              left_nxt    = part_time_left_r[sel_r[2:0]];
            end
          end
          default: begin
            status_nxt = ST_INVALID;
          end
        endcase
      end

      S_TICK_INC: begin
        alu_req.op     = ALU_ADD;
        alu_req.a      = frame_time_r;
        alu_req.b      = FRAME_W'(1);
        frame_time_nxt = alu_rsp.res;
        state_nxt      = S_TICK_CMP;
      end

      S_TICK_CMP: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = frame_time_r;
        alu_req.b  = win_end_r[cur_window_r];
        if (alu_rsp.carry) begin
          state_nxt = S_CREDIT;
        end else if (active_on_r) begin
          state_nxt = S_RUN_LEFT;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_RUN_LEFT: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = FRAME_W'(part_time_left_r[active_part_r]);
        alu_req.b  = FRAME_W'(1);
        if (part_time_left_r[active_part_r] != '0) begin
          part_time_left_nxt[active_part_r] = alu_rsp.res[TIME_W-1:0];
        end
        state_nxt = S_RUN_USED;
      end

      S_RUN_USED: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = FRAME_W'(part_time_used_r[active_part_r]);
        alu_req.b  = FRAME_W'(1);
        part_time_used_nxt[active_part_r] = alu_rsp.res[TIME_W-1:0];
        state_nxt = S_DONE;
      end

      S_CREDIT: begin
        sw_nxt     = 1'b1;
        alu_req.op = ALU_ADD;
        alu_req.a  = FRAME_W'(part_time_used_r[active_part_r]);
        alu_req.b  = FRAME_W'(win_len_r[cur_window_r]);
        if (active_on_r) begin
          part_time_left_nxt[active_part_r] = '0;
          part_time_used_nxt[active_part_r] = alu_rsp.res[TIME_W-1:0];
        end
        // frame wrap reloads every used partition first
        if ((win_next >= win_total_r) || (win_next >= 4'(NUM_WIN))) begin
          nxt_win_r_nxt  = '0;
          frame_time_nxt = '0;
          idx_nxt        = '0;
          state_nxt      = S_RELOAD;
        end else begin
          nxt_win_r_nxt = win_next[WIN_IDX_W-1:0];
          state_nxt     = S_SELECT;
        end
      end

      S_RELOAD: begin
        if (part_used_r[idx_r]) begin
          part_time_used_nxt[idx_r] = '0;
          part_time_left_nxt[idx_r] = part_budget_r[idx_r];
        end
        idx_nxt = idx_r + 3'd1;
        if (idx_r == 3'(MAX_PARTS - 1)) begin
          state_nxt = S_SELECT;
        end
      end

      S_SELECT: begin
        cur_window_nxt = nxt_win_r;
        if (!sel_part[3] && part_used_r[sel_part[2:0]]) begin
          active_on_nxt                        = 1'b1;
          active_part_nxt                      = sel_part[2:0];
          part_time_left_nxt[sel_part[2:0]]    = win_len_r[nxt_win_r];
        end else begin
          active_on_nxt = 1'b0;
        end
        state_nxt = S_DONE;
      end

      S_CHECK: begin
        if (win_part_r[idx_r][3] || (win_len_r[idx_r] == '0)) begin
          status_nxt = ST_INVALID;
          state_nxt  = S_DONE;
        end else if (last_entry) begin
          idx_nxt   = '0;
          off_nxt   = '0;
          state_nxt = S_ACCUM;
        end else begin
          idx_nxt = idx_r + 3'd1;
        end
      end

      S_ACCUM: begin
        alu_req.op          = ALU_ADD;
        alu_req.a           = off_r;
        alu_req.b           = FRAME_W'(win_len_r[idx_r]);
        off_nxt             = alu_rsp.res;
        win_end_nxt[idx_r]  = alu_rsp.res;
        if (last_entry) begin
          win_total_nxt  = count_r;
          frame_time_nxt = '0;
          cur_window_nxt = '0;
          sched_on_nxt   = 1'b1;
          state_nxt      = S_DONE;
        end else begin
          idx_nxt = idx_r + 3'd1;
        end
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          o_status_nxt  = status_r;
          o_pid_nxt     = created_r ? new_id_r : active_part_r;
          o_act_nxt     = active_on_r;
          o_win_nxt     = cur_window_r;
          o_sw_nxt      = sw_r;
          o_pres_nxt    = present_r;
          o_used_nxt    = used_r;
          o_left_nxt    = left_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      part_used_r      <= '0;
      win_total_r      <= '0;
      frame_time_r     <= '0;
      cur_window_r     <= '0;
      active_on_r      <= 1'b0;
      active_part_r    <= '0;
      sched_on_r       <= 1'b0;
      out_valid_r      <= 1'b0;
      for (int i = 0; i < MAX_PARTS; i++) begin
        part_budget_r[i]    <= '0;
        part_time_used_r[i] <= '0;
        part_time_left_r[i] <= '0;
      end
      for (int i = 0; i < NUM_WIN; i++) begin
        win_part_r[i] <= '0;
        win_len_r[i]  <= '0;
        win_end_r[i]  <= '0;
      end
    end else begin
      state_r          <= state_nxt;
      part_used_r      <= part_used_nxt;
      part_budget_r    <= part_budget_nxt;
      part_time_used_r <= part_time_used_nxt;
      part_time_left_r <= part_time_left_nxt;
      win_part_r       <= win_part_nxt;
      win_len_r        <= win_len_nxt;
      win_end_r        <= win_end_nxt;
      win_total_r      <= win_total_nxt;
      frame_time_r     <= frame_time_nxt;
      cur_window_r     <= cur_window_nxt;
      active_on_r      <= active_on_nxt;
      active_part_r    <= active_part_nxt;
      sched_on_r       <= sched_on_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    action_r   <= action_nxt;
    slot_r     <= slot_nxt;
    sel_r      <= sel_nxt;
    period_r   <= period_nxt;
    ticks_r    <= ticks_nxt;
    count_r    <= count_nxt;
    idx_r      <= idx_nxt;
    nxt_win_r  <= nxt_win_r_nxt;
    off_r      <= off_nxt;
    status_r   <= status_nxt;
    created_r  <= created_nxt;
    new_id_r   <= new_id_nxt;
    sw_r       <= sw_nxt;
    present_r  <= present_nxt;
    used_r     <= used_nxt;
    left_r     <= left_nxt;
    o_status_r <= o_status_nxt;
    o_pid_r    <= o_pid_nxt;
    o_act_r    <= o_act_nxt;
    o_win_r    <= o_win_nxt;
    o_sw_r     <= o_sw_nxt;
    o_pres_r   <= o_pres_nxt;
    o_used_r   <= o_used_nxt;
    o_left_r   <= o_left_nxt;
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = o_status_r;
  assign out_part_id      = o_pid_r;
  assign out_active_valid = o_act_r;
  assign out_window_index = o_win_r;
  assign out_switched     = o_sw_r;
  assign out_present      = o_pres_r;
  assign out_used_ticks   = o_used_r;
  assign out_left_ticks   = o_left_r;

endmodule

### rtl/core/tpws_checker.sv
// ----------------------------------------------------------------------------
// tpws_checker
// Port-level checks of the window scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module tpws_checker
  import tpws_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic        out_switched,
  input logic        out_present,
  input logic [31:0] out_used_ticks
);

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while previous item still in work");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_status) &&
                                  $stable(out_used_ticks)))
    else $error("stalled result item changed");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_INVALID ||
                   out_status == ST_FULL))
    else $error("unknown status code");

  a_present_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_present) |-> (out_status == ST_OK && !out_switched))
    else $error("present item with error status or switch");

  a_switch_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_switched) |-> (out_status == ST_OK && !out_present))
    else $error("window switch reported with error status");

endmodule

bind time_partition_window_scheduler_top tpws_checker u_tpws_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_status     (out_status),
  .out_switched   (out_switched),
  .out_present    (out_present),
  .out_used_ticks (out_used_ticks)
);
